>>> hw/rtl/swlrl_pkg.sv
// ----------------------------------------------------------------------------
// swlrl_pkg
// Shared types and constants for the sliding-window log rate limiter.
// ----------------------------------------------------------------------------
package swlrl_pkg;

    // Key slots and ring depth are powers of two; slot and ring positions
    // wrap by truncation.
    localparam int KEY_SLOTS  = 64;
    localparam int RING_DEPTH = 16;

    localparam int KEY_W     = $clog2(KEY_SLOTS);
    localparam int PTR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int STAMP_W   = 32;
    localparam int MAXREQ_W  = 5;
    localparam int WINDOW_W  = 16;
    localparam int RETRY_W   = 16;
    localparam int LIM_W     = (CNT_W > MAXREQ_W) ? CNT_W : MAXREQ_W;
    localparam int STORE_DEPTH = KEY_SLOTS * RING_DEPTH;
    localparam int STORE_AW  = KEY_W + PTR_W;

    // Stream payload widths, padded to whole bytes.
    localparam int S_FIELDS_W = KEY_W + STAMP_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + RETRY_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 2'd1;

    // Item kinds.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    // Per-key ring bookkeeping kept in the metadata RAM.
    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [CNT_W-1:0] count;
    } meta_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_META,
        S_LOAD,
        S_SCAN,
        S_CHECK,
        S_RETRY,
        S_DECIDE,
        S_FINISH
    } state_t;

endpackage

>>> hw/rtl/sliding_window_log_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// sliding_window_log_rate_limiter_top
// Per-key sliding-window log rate limiter with a ring of stamps per key.
// ----------------------------------------------------------------------------
// Flow: with limiting disabled an item goes straight to the result; else the key's
//   ring bookkeeping is read, expired stamps are dropped one at a time (at most
//   RING_DEPTH), and the oldest live stamp or an empty ring decides the result.
// Throughput: one item at a time; s_tready returns as the result is loaded.
// Reset: aresetn (synchronous, active low) empties every key, clears both
//   registers to zero and drops any pending result. Stamp RAM is not cleared.
// ----------------------------------------------------------------------------
module sliding_window_log_rate_limiter_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swlrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swlrl_pkg::CFG_DATA_W-1:0]    cfg_data,

    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [swlrl_pkg::S_TDATA_W-1:0]     s_tdata,  // key_index, now_seconds
    input  logic                                s_tuser,  // kind

    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swlrl_pkg::M_TDATA_W-1:0]     m_tdata   // allowed, retry_after
);

    import swlrl_pkg::*;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                 state_reg, state_next;

    logic [MAXREQ_W-1:0]    max_requests_reg;
    logic [WINDOW_W-1:0]    window_reg;

    // Item being worked on.
    logic                   kind_reg, kind_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [STAMP_W-1:0]     now_reg, now_next;

    // Working copy of the key's ring position.
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    // Result of the shared compare: now - stamp and whether now is later.
    logic [STAMP_W-1:0]     diff_reg, diff_next;
    logic                   later_reg, later_next;

    logic                   res_allowed_reg, res_allowed_next;
    logic [RETRY_W-1:0]     res_retry_reg, res_retry_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   out_allowed_reg, out_allowed_next;
    logic [RETRY_W-1:0]     out_retry_reg, out_retry_next;

    // One valid bit per key; an invalid key reads as empty.
    logic [KEY_SLOTS-1:0]   meta_valid_reg;

    // ------------------------------------------------------------------------
    // RAM control
    // ------------------------------------------------------------------------
    logic                   meta_we, meta_re;
    meta_t                  meta_wdata, meta_rdata;

    logic                   stamp_we, stamp_re;
    logic [STORE_AW-1:0]    stamp_waddr, stamp_raddr;
    logic [STAMP_W-1:0]     stamp_rdata;

    // ------------------------------------------------------------------------
    // Shared arithmetic and derived values
    // ------------------------------------------------------------------------
    logic                   s_accept;
    logic                   limit_off;
    logic [LIM_W-1:0]       limit_w;
    logic [STAMP_W:0]       sub_w;
    logic                   later_w;
    logic                   expired_w;
    logic [PTR_W-1:0]       tail_ptr_w;
    logic [STAMP_W-1:0]     ahead_w;
    logic [STAMP_W:0]       wait_w;
    logic [RETRY_W-1:0]     retry_w;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_retry_reg, out_allowed_reg};

    assign limit_off = (max_requests_reg == '0) || (window_reg == '0);

    // Clamp the limit to what a ring can hold.
    assign limit_w = (LIM_W'(max_requests_reg) > LIM_W'(RING_DEPTH))
                     ? LIM_W'(RING_DEPTH) : LIM_W'(max_requests_reg);

    // The one subtract-and-compare that every scan step reuses.
    assign sub_w     = {1'b0, now_reg} - {1'b0, stamp_rdata};
    assign later_w   = !sub_w[STAMP_W] && (sub_w[STAMP_W-1:0] != '0);
    assign expired_w = later_w && (sub_w[STAMP_W-1:0] > STAMP_W'(window_reg));

    assign tail_ptr_w = head_reg + count_reg[PTR_W-1:0];

    // Wait until the oldest live stamp leaves the window. When now is later,
    // the gap already fits the window; otherwise saturate stamp - now + window.
    assign ahead_w = '0 - diff_reg;
    assign wait_w  = {1'b0, ahead_w} + (STAMP_W + 1)'(window_reg);
    always_comb begin
        if (later_reg) begin
            retry_w = window_reg - diff_reg[RETRY_W-1:0];
        end else if (wait_w[STAMP_W:RETRY_W] != '0) begin
            retry_w = '1;
        end else begin
            retry_w = wait_w[RETRY_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    swlrl_ram #(
        .WIDTH ($bits(meta_t)),
        .DEPTH (KEY_SLOTS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (key_reg),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (key_reg),
        .rdata (meta_rdata)
    );

    swlrl_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (STORE_DEPTH)
    ) u_stamp_ram (
        .aclk  (aclk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (now_reg),
        .re    (stamp_re),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_requests_reg <= '0;
            window_reg       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAX_REQUESTS:   max_requests_reg <= cfg_data[MAXREQ_W-1:0];
                CFG_WINDOW_SECONDS: window_reg       <= cfg_data[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // State and control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            meta_valid_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (meta_we) begin
                meta_valid_reg[key_reg] <= 1'b1;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        kind_reg        <= kind_next;
        key_reg         <= key_next;
        now_reg         <= now_next;
        head_reg        <= head_next;
        count_reg       <= count_next;
        diff_reg        <= diff_next;
        later_reg       <= later_next;
        res_allowed_reg <= res_allowed_next;
        res_retry_reg   <= res_retry_next;
        out_allowed_reg <= out_allowed_next;
        out_retry_reg   <= out_retry_next;
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ------------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        diff_next        = diff_reg;
        later_next       = later_reg;
        res_allowed_next = res_allowed_reg;
        res_retry_next   = res_retry_reg;
        out_allowed_next = out_allowed_reg;
        out_retry_next   = out_retry_reg;

        // Drop the output item once taken; FINISH may refill it below.
        m_tvalid_next    = m_tvalid_reg && !m_tready;

        meta_we          = 1'b0;
        meta_re          = 1'b0;
        meta_wdata       = '{head: head_reg, count: count_reg};
        stamp_we         = 1'b0;
        stamp_re         = 1'b0;
        stamp_waddr      = {key_reg, tail_ptr_w};
        stamp_raddr      = {key_reg, head_reg};

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    kind_next        = s_tuser;
                    key_next         = s_tdata[KEY_W-1:0];
                    now_next         = s_tdata[KEY_W +: STAMP_W];
                    res_allowed_next = 1'b0;
                    res_retry_next   = '0;
                    if (limit_off) begin
                        // Limiting disabled: pass requests, report zero wait.
                        res_allowed_next = (s_tuser == KIND_REQUEST);
                        state_next       = S_FINISH;
                    end else begin
                        state_next = S_META;
                    end
                end
            end

            S_META: begin
                meta_re    = 1'b1;
                state_next = S_LOAD;
            end

            S_LOAD: begin
                if (meta_valid_reg[key_reg]) begin
                    head_next  = meta_rdata.head;
                    count_next = meta_rdata.count;
                end else begin
                    head_next  = '0;
                    count_next = '0;
                end
                state_next = S_SCAN;
            end

            S_SCAN: begin
                if (count_reg == '0) begin
                    state_next = (kind_reg == KIND_REQUEST) ? S_DECIDE : S_FINISH;
                end else begin
                    stamp_re   = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK: begin
                diff_next  = sub_w[STAMP_W-1:0];
                later_next = later_w;
                if (expired_w) begin
                    // Advance past the expired stamp; a query only walks.
                    head_next  = head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = S_SCAN;
                end else begin
                    state_next = (kind_reg == KIND_REQUEST) ? S_DECIDE : S_RETRY;
                end
            end

            S_RETRY: begin
                res_retry_next = retry_w;
                state_next     = S_FINISH;
            end

            S_DECIDE: begin
                // Write back the drops, and record now if there is room.
                meta_we = 1'b1;
                if (LIM_W'(count_reg) < limit_w) begin
                    stamp_we         = 1'b1;
                    res_allowed_next = 1'b1;
                    meta_wdata.count = count_reg + 1'b1;
                end
                state_next = S_FINISH;
            end

            S_FINISH: begin
                // Hold until the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next    = 1'b1;
                    out_allowed_next = res_allowed_reg;
                    out_retry_next   = res_retry_reg;
                    state_next       = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A stamp is recorded only when the key's ring is below the limit.
    a_stamp_room: assert property (@(posedge aclk) disable iff (!aresetn)
        stamp_we |-> (LIM_W'(count_reg) < limit_w))
        else $error("stamp written into a full ring");

    // Only requests write back ring bookkeeping.
    a_meta_req_only: assert property (@(posedge aclk) disable iff (!aresetn)
        meta_we |-> (kind_reg == KIND_REQUEST))
        else $error("query changed ring state");

    // A query never reports allowed.
    a_query_not_allowed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && kind_reg == KIND_QUERY) |-> !res_allowed_reg)
        else $error("query result marked allowed");

    // A working count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_DECIDE)
            |-> (count_reg <= CNT_W'(RING_DEPTH)))
        else $error("ring count above depth");

endmodule

>>> hw/rtl/swlrl_ram.sv
// ----------------------------------------------------------------------------
// swlrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swlrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
